FILE: sv/fmspd_pkg.sv
package fmspd_pkg;

	localparam int FREQ_W = 17;
	localparam int STEP_W = 12;
	localparam int VAL_W  = 8;

	typedef logic [FREQ_W-1:0]        freq_t;
	typedef logic signed [VAL_W-1:0]  val_t;
	typedef logic signed [VAL_W:0]    val9_t;
	typedef logic signed [STEP_W:0]   step_t;
	typedef logic signed [FREQ_W+1:0] cand_t;

	// input selector carried in s_tuser
	localparam logic OP_START  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// result kind carried in m_tuser
	localparam logic KIND_TUNE = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	// register indexes on the configuration port
	localparam int CFG_ADDR_W = 3;
	localparam logic [CFG_ADDR_W-1:0] REG_BAND_LOW    = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_BAND_HIGH   = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_STEP_SIZE   = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_PEAK_RISE   = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_SNR_MIN     = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_STEREO_OFS  = 3'd5;
	localparam logic [CFG_ADDR_W-1:0] REG_CHAN_CUT    = 3'd6;
	localparam logic [CFG_ADDR_W-1:0] REG_STEREO_CUT  = 3'd7;

	// register reset values
	localparam freq_t              RST_BAND_LOW   = 17'd87400;
	localparam freq_t              RST_BAND_HIGH  = 17'd108000;
	localparam logic [STEP_W-1:0]  RST_STEP_SIZE  = 12'd100;
	localparam val_t               RST_PEAK_RISE  = 8'sd8;
	localparam val_t               RST_SNR_MIN    = 8'sd4;
	localparam val_t               RST_STEREO_OFS = 8'sd22;
	localparam val_t               RST_CHAN_CUT   = 8'sd15;
	localparam val_t               RST_STEREO_CUT = 8'sd12;

	// frequency that is never reported as a station
	localparam freq_t BAD_FREQ      = 17'd96000;
	localparam val_t  HIGH_TH_EXTRA = 8'sd10;
	localparam val_t  SNR_FLOOR     = -8'sd1;

	function automatic val9_t sx9(input val_t v);
		return val9_t'(v);
	endfunction

	// below the band goes to the top, then above the band goes to the bottom
	function automatic freq_t wrap_band(input cand_t f, input freq_t lo, input freq_t hi);
		cand_t g;
		g = f;
		if (g < $signed({2'b00, lo})) begin
			g = $signed({2'b00, hi});
		end
		if (g > $signed({2'b00, hi})) begin
			g = $signed({2'b00, lo});
		end
		return g[FREQ_W-1:0];
	endfunction

endpackage

FILE: sv/fm_seek_peak_detector_unit.sv
// FM seek peak detector. A start transaction (s_tuser = 0) sets the start frequency and the
// direction and is answered by a tune result for the first candidate (a done result if it
// is the end point); each group of SAMPLES_PER_FREQ readback transactions (s_tuser = 1)
// closes one measurement, answered by the next tune result or by a done result
// (m_tuser = 1) carrying the chosen frequency, the found flag, the stereo thresholds and
// the hi-cut enables. Other samples, and samples while idle, give no result. One
// transaction is accepted every clock cycle unless the output stalls; results pass the
// input register, then the result register; window and measurement registers update as it
// loads. The configuration port is always ready; write registers only while idle.
module fm_seek_peak_detector_unit #(
	parameter int SAMPLES_PER_FREQ = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // start_khz[16:0], seek_down[17], rssi_sample[25:18],
	                              // snr_sample[33:26], zero fill
	input  logic        s_tuser,  // op
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // freq_khz[16:0], found[17], stereo_low_th[25:18],
	                              // stereo_high_th[33:26], channel_cut_on[34],
	                              // stereo_cut_on[35], zero fill
	output logic        m_tuser,  // kind
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_addr,
	input  logic [16:0] cfg_data
);

	// accumulator wide enough for the sum of all samples of one frequency
	localparam int SUM_W   = 8 + $clog2(SAMPLES_PER_FREQ);
	localparam int CNT_W   = $clog2(SAMPLES_PER_FREQ + 1);
	// mean by reciprocal multiply: exact for |sum| < 2^20 / SAMPLES_PER_FREQ
	localparam int RCP_SH  = 20;
	localparam int RCP_W   = RCP_SH + 1;
	localparam int PROD_W  = SUM_W + RCP_W;
	localparam logic [RCP_W-1:0] RCP_C = RCP_W'((1 << RCP_SH) / SAMPLES_PER_FREQ + 1);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_FREQ);

	// configuration registers
	fmspd_pkg::freq_t     band_low_q, band_high_q;
	logic [11:0]          step_size_q;
	fmspd_pkg::val_t      peak_rise_q, snr_min_q, stereo_ofs_q, chan_cut_q, stereo_cut_q;

	// input register
	logic                 valid_s1;
	logic                 op_s1;
	fmspd_pkg::freq_t     start_s1;
	logic                 down_s1;
	fmspd_pkg::val_t      rssi_s1, snr_s1;

	// seek state
	logic                 seeking_q;
	fmspd_pkg::step_t     step_q;
	fmspd_pkg::freq_t     end_q, fallback_q;
	fmspd_pkg::freq_t     win_freq_q [4];
	fmspd_pkg::val_t      win_rssi_q [4];
	fmspd_pkg::val_t      win_snr_q  [4];
	logic [1:0]           fill_q;
	logic [CNT_W-1:0]     cnt_q;
	logic signed [SUM_W-1:0] sum_q;
	fmspd_pkg::val_t      peak_q;

	// next state
	logic                 seeking_n;
	fmspd_pkg::step_t     step_n;
	fmspd_pkg::freq_t     end_n, fallback_n;
	fmspd_pkg::freq_t     win_freq_n [4];
	fmspd_pkg::val_t      win_rssi_n [4];
	fmspd_pkg::val_t      win_snr_n  [4];
	logic [1:0]           fill_n;
	logic [CNT_W-1:0]     cnt_n;
	logic signed [SUM_W-1:0] sum_n;
	fmspd_pkg::val_t      peak_n;

	// result register
	logic                 out_valid_q;
	logic                 kind_q, found_q, ccut_q, scut_q;
	fmspd_pkg::freq_t     freq_q;
	logic [7:0]           lo_th_q, hi_th_q;

	logic                 res_valid, res_kind, res_found, res_ccut, res_scut;
	fmspd_pkg::freq_t     res_freq;
	logic [7:0]           res_lo, res_hi;

	// handshake: the s1 item moves on whenever the result register can take a value
	logic                 out_free, adv;

	// measurement datapath
	logic signed [SUM_W-1:0] sum_new;
	fmspd_pkg::val_t      peak_new;
	logic [CNT_W-1:0]     cnt_new;
	logic [SUM_W-1:0]     sum_mag;
	logic [PROD_W-1:0]    prod;
	fmspd_pkg::val9_t     quot9, mean9;
	fmspd_pkg::val_t      mean;

	// candidate datapath
	fmspd_pkg::freq_t     cand_base, cand, cmp_end, start_wrap;
	fmspd_pkg::step_t     cand_step, start_step;

	// peak test
	fmspd_pkg::val9_t     r0, r1, r2, r3, rise2, rise1, rise_sel;
	logic                 peak2, peak1;
	fmspd_pkg::val_t      noise_sel, lo_sel;

	assign out_free  = !out_valid_q || m_tready;
	assign s_tready  = !valid_s1 || out_free;
	assign adv       = valid_s1 && out_free;
	assign cfg_ready = 1'b1;

	assign m_tvalid = out_valid_q;
	assign m_tuser  = kind_q;
	assign m_tdata  = {4'b0000, scut_q, ccut_q, hi_th_q, lo_th_q, found_q, freq_q};

	// accumulate the current sample
	assign sum_new  = sum_q + SUM_W'(rssi_s1);
	assign peak_new = (snr_s1 > peak_q) ? snr_s1 : peak_q;
	assign cnt_new  = cnt_q + 1'b1;

	// mean truncated toward zero: divide the magnitude, then restore the sign
	assign sum_mag = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);
	assign prod    = PROD_W'(sum_mag) * PROD_W'(RCP_C);
	assign quot9   = $signed({1'b0, prod[RCP_SH +: 8]});
	assign mean9   = sum_new[SUM_W-1] ? -quot9 : quot9;
	assign mean    = mean9[7:0];

	// start transaction: direction and wrapped end point
	assign start_step = down_s1 ? -$signed({1'b0, step_size_q}) : $signed({1'b0, step_size_q});
	assign start_wrap = fmspd_pkg::wrap_band($signed({2'b00, start_s1}), band_low_q, band_high_q);

	// next candidate: from the start point, or from the newest window frequency
	assign cand_base = (op_s1 == fmspd_pkg::OP_START) ? start_s1 : win_freq_q[3];
	assign cand_step = (op_s1 == fmspd_pkg::OP_START) ? start_step : step_q;
	assign cmp_end   = (op_s1 == fmspd_pkg::OP_START) ? start_wrap : end_q;
	assign cand = fmspd_pkg::wrap_band($signed({2'b00, cand_base})
		+ $signed({{(fmspd_pkg::FREQ_W + 1 - fmspd_pkg::STEP_W){cand_step[fmspd_pkg::STEP_W]}},
		cand_step}), band_low_q, band_high_q);

	// peak test on the window with the new measurement in slot 3
	assign r0 = fmspd_pkg::sx9(win_rssi_q[0]);
	assign r1 = fmspd_pkg::sx9(win_rssi_q[1]);
	assign r2 = fmspd_pkg::sx9(win_rssi_q[2]);
	assign r3 = fmspd_pkg::sx9(mean);
	assign rise2 = r2 - r0;
	assign rise1 = r1 - r3;

	assign peak2 = (r2 >= r0 + fmspd_pkg::sx9(peak_rise_q)) && (r3 <= r2) && (r1 <= r2)
		&& (win_snr_q[2] >= snr_min_q) && (win_freq_q[2] != fmspd_pkg::BAD_FREQ);
	assign peak1 = (r1 >= r3 + fmspd_pkg::sx9(peak_rise_q)) && (r0 <= r1) && (r3 <= r2)
		&& (win_snr_q[1] >= snr_min_q) && (win_freq_q[1] != fmspd_pkg::BAD_FREQ);

	assign rise_sel  = peak2 ? rise2 : rise1;
	assign noise_sel = peak2 ? win_rssi_q[0] : mean;
	assign lo_sel    = noise_sel + stereo_ofs_q;

	always_comb begin
		logic do_next;
		seeking_n  = seeking_q;
		step_n     = step_q;
		end_n      = end_q;
		fallback_n = fallback_q;
		fill_n     = fill_q;
		cnt_n      = cnt_q;
		sum_n      = sum_q;
		peak_n     = peak_q;
		for (int i = 0; i < 4; i++) begin
			win_freq_n[i] = win_freq_q[i];
			win_rssi_n[i] = win_rssi_q[i];
			win_snr_n[i]  = win_snr_q[i];
		end
		res_valid = 1'b0;
		res_kind  = fmspd_pkg::KIND_TUNE;
		res_freq  = '0;
		res_found = 1'b0;
		res_lo    = '0;
		res_hi    = '0;
		res_ccut  = 1'b0;
		res_scut  = 1'b0;
		do_next   = 1'b0;

		if (op_s1 == fmspd_pkg::OP_START) begin
			// a running seek is dropped
			step_n     = start_step;
			fallback_n = start_s1;
			end_n      = start_wrap;
			for (int i = 0; i < 4; i++) begin
				win_freq_n[i] = '0;
				win_rssi_n[i] = '0;
				win_snr_n[i]  = '0;
			end
			fill_n    = '0;
			seeking_n = 1'b1;
			do_next   = 1'b1;
		end else if (seeking_q) begin
			if (cnt_new == CNT_LAST) begin
				// measurement complete
				win_rssi_n[3] = mean;
				win_snr_n[3]  = peak_new;
				cnt_n  = '0;
				sum_n  = '0;
				peak_n = fmspd_pkg::SNR_FLOOR;
				if (fill_q != 2'd3) begin
					fill_n = fill_q + 2'd1;
				end
				if (fill_n == 2'd3 && (peak2 || peak1)) begin
					seeking_n = 1'b0;
					res_valid = 1'b1;
					res_kind  = fmspd_pkg::KIND_DONE;
					res_freq  = peak2 ? win_freq_q[2] : win_freq_q[1];
					res_found = 1'b1;
					res_lo    = lo_sel;
					res_hi    = lo_sel + fmspd_pkg::HIGH_TH_EXTRA;
					res_ccut  = rise_sel < fmspd_pkg::sx9(chan_cut_q);
					res_scut  = rise_sel < fmspd_pkg::sx9(stereo_cut_q);
				end else begin
					// no peak: window moves down one slot
					for (int i = 0; i < 3; i++) begin
						win_freq_n[i] = win_freq_n[i+1];
						win_rssi_n[i] = win_rssi_n[i+1];
						win_snr_n[i]  = win_snr_n[i+1];
					end
					do_next = 1'b1;
				end
			end else begin
				cnt_n  = cnt_new;
				sum_n  = sum_new;
				peak_n = peak_new;
			end
		end

		if (do_next) begin
			res_valid = 1'b1;
			if (cand == cmp_end) begin
				// back at the start point without a station
				seeking_n = 1'b0;
				res_kind  = fmspd_pkg::KIND_DONE;
				res_freq  = (op_s1 == fmspd_pkg::OP_START) ? start_s1 : fallback_q;
			end else begin
				win_freq_n[3] = cand;
				cnt_n    = '0;
				sum_n    = '0;
				peak_n   = fmspd_pkg::SNR_FLOOR;
				res_kind = fmspd_pkg::KIND_TUNE;
				res_freq = cand;
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_low_q   <= fmspd_pkg::RST_BAND_LOW;
			band_high_q  <= fmspd_pkg::RST_BAND_HIGH;
			step_size_q  <= fmspd_pkg::RST_STEP_SIZE;
			peak_rise_q  <= fmspd_pkg::RST_PEAK_RISE;
			snr_min_q    <= fmspd_pkg::RST_SNR_MIN;
			stereo_ofs_q <= fmspd_pkg::RST_STEREO_OFS;
			chan_cut_q   <= fmspd_pkg::RST_CHAN_CUT;
			stereo_cut_q <= fmspd_pkg::RST_STEREO_CUT;
		end else if (cfg_valid) begin
			case (cfg_addr)
				fmspd_pkg::REG_BAND_LOW:   band_low_q   <= cfg_data;
				fmspd_pkg::REG_BAND_HIGH:  band_high_q  <= cfg_data;
				fmspd_pkg::REG_STEP_SIZE:  step_size_q  <= cfg_data[11:0];
				fmspd_pkg::REG_PEAK_RISE:  peak_rise_q  <= cfg_data[7:0];
				fmspd_pkg::REG_SNR_MIN:    snr_min_q    <= cfg_data[7:0];
				fmspd_pkg::REG_STEREO_OFS: stereo_ofs_q <= cfg_data[7:0];
				fmspd_pkg::REG_CHAN_CUT:   chan_cut_q   <= cfg_data[7:0];
				fmspd_pkg::REG_STEREO_CUT: stereo_cut_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1    <= s_tuser;
			start_s1 <= s_tdata[16:0];
			down_s1  <= s_tdata[17];
			rssi_s1  <= s_tdata[25:18];
			snr_s1   <= s_tdata[33:26];
		end
	end

	// seek state, updated when the s1 transaction is consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seeking_q  <= 1'b0;
			step_q     <= '0;
			end_q      <= '0;
			fallback_q <= '0;
			fill_q     <= '0;
			cnt_q      <= '0;
			sum_q      <= '0;
			peak_q     <= fmspd_pkg::SNR_FLOOR;
			for (int i = 0; i < 4; i++) begin
				win_freq_q[i] <= '0;
				win_rssi_q[i] <= '0;
				win_snr_q[i]  <= '0;
			end
		end else if (adv) begin
			seeking_q  <= seeking_n;
			step_q     <= step_n;
			end_q      <= end_n;
			fallback_q <= fallback_n;
			fill_q     <= fill_n;
			cnt_q      <= cnt_n;
			sum_q      <= sum_n;
			peak_q     <= peak_n;
			for (int i = 0; i < 4; i++) begin
				win_freq_q[i] <= win_freq_n[i];
				win_rssi_q[i] <= win_rssi_n[i];
				win_snr_q[i]  <= win_snr_n[i];
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= adv && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			kind_q  <= res_kind;
			freq_q  <= res_freq;
			found_q <= res_found;
			lo_th_q <= res_lo;
			hi_th_q <= res_hi;
			ccut_q  <= res_ccut;
			scut_q  <= res_scut;
		end
	end

endmodule

FILE: tb/tb_top.sv
module tb_top;

	localparam int SPF         = 5;     // readback samples per candidate frequency
	localparam int LAT_PAD     = 8;     // cycles to let the two-stage pipeline drain
	localparam int QUIET_LIMIT = 2000;  // cycles without any transaction before giving up
	localparam int HOLD_CYCLES = 400;   // long receiver hold-off to back the block up

	// one input transaction, fields as the block sees them
	typedef struct packed {
		logic             op;
		fmspd_pkg::freq_t start;
		logic             down;
		fmspd_pkg::val_t  rssi;
		fmspd_pkg::val_t  snr;
	} seek_item_t;

	// one result transaction
	typedef struct packed {
		logic             kind;
		fmspd_pkg::freq_t freq;
		logic             found;
		logic [7:0]       lo_th;
		logic [7:0]       hi_th;
		logic             ccut;
		logic             scut;
	} seek_result_t;

	// clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// block ports, all known from time zero
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic        s_tuser = fmspd_pkg::OP_START;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_addr = fmspd_pkg::REG_BAND_LOW;
	logic [16:0] cfg_data = '0;

	// stimulus and expected results
	seek_item_t   stim_q[$];
	seek_result_t seek_results_due[$];
	seek_item_t   s_item = '0;        // transaction currently offered on the input
	logic         in_taken = 1'b0;    // input transaction completed at the last rising edge
	logic         out_taken = 1'b0;   // result transaction completed at the last rising edge
	int           in_gap = 0;
	int           out_wait = 0;
	int           hold_left = 0;
	bit           hold_req = 0;
	bit           no_idle = 0;
	int           accepted_items = 0; // every accepted input transaction
	int           mismatch_count = 0;
	int           quiet_cycles = 0;

	// predictor copy of the registers
	fmspd_pkg::freq_t band_lo = fmspd_pkg::RST_BAND_LOW;
	fmspd_pkg::freq_t band_hi = fmspd_pkg::RST_BAND_HIGH;
	logic [11:0]      step_khz = fmspd_pkg::RST_STEP_SIZE;
	fmspd_pkg::val_t  rise_min = fmspd_pkg::RST_PEAK_RISE;
	fmspd_pkg::val_t  snr_need = fmspd_pkg::RST_SNR_MIN;
	fmspd_pkg::val_t  stereo_ofs = fmspd_pkg::RST_STEREO_OFS;
	fmspd_pkg::val_t  chan_cut_rise = fmspd_pkg::RST_CHAN_CUT;
	fmspd_pkg::val_t  lr_cut_rise = fmspd_pkg::RST_STEREO_CUT;

	// predictor copy of the seek state
	bit seek_on = 0;
	int step_dir = 0;
	int end_khz = 0;
	int fallback_khz = 0;
	int win_f[4];
	int win_r[4];
	int win_s[4];
	int win_fill = 0;
	int meas_n = 0;
	int meas_sum = 0;
	int meas_snr = int'(fmspd_pkg::SNR_FLOOR);

	fm_seek_peak_detector_unit #(
		.SAMPLES_PER_FREQ(SPF)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------

	// below the band goes to the top, then above the band goes to the bottom
	function automatic int wrap_khz(input int f);
		if (f < int'(band_lo)) f = int'(band_hi);
		if (f > int'(band_hi)) f = int'(band_lo);
		return f;
	endfunction

	function automatic void restart_measure();
		meas_n   = 0;
		meas_sum = 0;
		meas_snr = int'(fmspd_pkg::SNR_FLOOR);
	endfunction

	// next candidate: either a tune request or, back at the start point, a not-found finish
	function automatic void tune_or_finish(input int cand, output seek_result_t r);
		cand = wrap_khz(cand);
		r = '0;
		if (cand == end_khz) begin
			seek_on = 0;
			r.kind  = fmspd_pkg::KIND_DONE;
			r.freq  = fmspd_pkg::freq_t'(fallback_khz);
		end else begin
			win_f[3] = cand;
			restart_measure();
			r.kind = fmspd_pkg::KIND_TUNE;
			r.freq = fmspd_pkg::freq_t'(cand);
		end
	endfunction

	// station accepted: thresholds wrap to 8 bits, hi-cut enables from the rise
	function automatic void report_station(input int f, input int noise, input int rise,
			output seek_result_t r);
		int low_i;
		low_i   = noise + int'(stereo_ofs);
		seek_on = 0;
		r       = '0;
		r.kind  = fmspd_pkg::KIND_DONE;
		r.freq  = fmspd_pkg::freq_t'(f);
		r.found = 1'b1;
		r.lo_th = 8'(low_i);
		r.hi_th = 8'(low_i + int'(fmspd_pkg::HIGH_TH_EXTRA));
		r.ccut  = (rise < int'(chan_cut_rise));
		r.scut  = (rise < int'(lr_cut_rise));
	endfunction

	// advance the seek model by one input transaction; returns 1 when a result is due
	function automatic bit seek_step(input seek_item_t it, output seek_result_t r);
		r = '0;
		if (it.op == fmspd_pkg::OP_START) begin
			step_dir     = it.down ? -int'(step_khz) : int'(step_khz);
			fallback_khz = int'(it.start);
			end_khz      = wrap_khz(int'(it.start));
			for (int i = 0; i < 4; i++) begin
				win_f[i] = 0;
				win_r[i] = 0;
				win_s[i] = 0;
			end
			win_fill = 0;
			seek_on  = 1;
			tune_or_finish(int'(it.start) + step_dir, r);
			return 1;
		end
		// samples while idle are dropped
		if (!seek_on) return 0;
		meas_sum += int'(it.rssi);
		if (int'(it.snr) > meas_snr) meas_snr = int'(it.snr);
		meas_n++;
		if (meas_n < SPF) return 0;
		// mean truncates toward zero
		win_r[3] = meas_sum / SPF;
		win_s[3] = meas_snr;
		restart_measure();
		if (win_fill < 3) win_fill++;
		if (win_fill == 3) begin
			// peak in slot 2, noise from slot 0
			if (win_r[2] >= win_r[0] + int'(rise_min) && win_r[3] <= win_r[2] &&
					win_r[1] <= win_r[2] && win_s[2] >= int'(snr_need) &&
					win_f[2] != int'(fmspd_pkg::BAD_FREQ)) begin
				report_station(win_f[2], win_r[0], win_r[2] - win_r[0], r);
				return 1;
			end
			// peak in slot 1, noise from slot 3
			if (win_r[1] >= win_r[3] + int'(rise_min) && win_r[0] <= win_r[1] &&
					win_r[3] <= win_r[2] && win_s[1] >= int'(snr_need) &&
					win_f[1] != int'(fmspd_pkg::BAD_FREQ)) begin
				report_station(win_f[1], win_r[3], win_r[1] - win_r[3], r);
				return 1;
			end
		end
		for (int i = 0; i < 3; i++) begin
			win_r[i] = win_r[i + 1];
			win_s[i] = win_s[i + 1];
			win_f[i] = win_f[i + 1];
		end
		tune_or_finish(win_f[2] + step_dir, r);
		return 1;
	endfunction

	// ------------------------------------------------------------------
	// driver, receiver, monitor, watchdog
	// ------------------------------------------------------------------

	function automatic int pick_gap();
		return no_idle ? 0 : int'($urandom_range(0, 5));
	endfunction

	// input side: offer the next pending item after its drawn gap
	always @(negedge clk) begin
		seek_item_t nxt;
		if (arst_n && (!s_tvalid || in_taken)) begin
			if (in_gap != 0) begin
				s_tvalid <= 1'b0;
				in_gap = in_gap - 1;
			end else if (stim_q.size() != 0) begin
				nxt = stim_q.pop_front();
				s_item   <= nxt;
				s_tdata  <= {6'd0, nxt.snr, nxt.rssi, nxt.down, nxt.start};
				s_tuser  <= nxt.op;
				s_tvalid <= 1'b1;
				in_gap = pick_gap();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result side: random wait per result, plus the long hold-off when asked
	always @(negedge clk) begin
		int nxt_wait;
		if (arst_n) begin
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 0;
			end
			nxt_wait = out_taken ? pick_gap() : out_wait;
			if (hold_left != 0) begin
				hold_left = hold_left - 1;
				out_wait  = nxt_wait;
				m_tready <= 1'b0;
			end else if (nxt_wait != 0) begin
				out_wait  = nxt_wait - 1;
				m_tready <= 1'b0;
			end else begin
				out_wait  = 0;
				m_tready <= 1'b1;
			end
		end
	end

	// check results first, then predict from the accepted input
	always @(posedge clk) begin
		seek_result_t got_r;
		seek_result_t exp_r;
		seek_result_t new_r;
		bit bad;
		in_taken  <= arst_n && s_tvalid && s_tready;
		out_taken <= arst_n && m_tvalid && m_tready;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got_r.kind  = m_tuser;
				got_r.freq  = m_tdata[16:0];
				got_r.found = m_tdata[17];
				got_r.lo_th = m_tdata[25:18];
				got_r.hi_th = m_tdata[33:26];
				got_r.ccut  = m_tdata[34];
				got_r.scut  = m_tdata[35];
				if (seek_results_due.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result: kind %0d freq %0d found %0d",
							got_r.kind, got_r.freq, got_r.found);
				end else begin
					exp_r = seek_results_due.pop_front();
					bad = (got_r.kind !== exp_r.kind) || (got_r.freq !== exp_r.freq) ||
						(got_r.found !== exp_r.found) || (got_r.lo_th !== exp_r.lo_th) ||
						(got_r.hi_th !== exp_r.hi_th) || (got_r.ccut !== exp_r.ccut) ||
						(got_r.scut !== exp_r.scut);
					if (bad) begin
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$display("exp: kind %0d freq %0d found %0d lo %0d hi %0d cc %0d sc %0d",
								exp_r.kind, exp_r.freq, exp_r.found, exp_r.lo_th,
								exp_r.hi_th, exp_r.ccut, exp_r.scut);
							$display("got: kind %0d freq %0d found %0d lo %0d hi %0d cc %0d sc %0d",
								got_r.kind, got_r.freq, got_r.found, got_r.lo_th,
								got_r.hi_th, got_r.ccut, got_r.scut);
						end
					end
				end
			end
			if (s_tvalid && s_tready) begin
				accepted_items++;
				if (seek_step(s_item, new_r)) seek_results_due.push_back(new_r);
			end
		end
	end

	// give up when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------

	task automatic push_item(input logic op, input int start, input logic down,
			input int rssi, input int snr);
		seek_item_t it;
		it.op    = op;
		it.start = fmspd_pkg::freq_t'(start);
		it.down  = down;
		it.rssi  = fmspd_pkg::val_t'(rssi);
		it.snr   = fmspd_pkg::val_t'(snr);
		stim_q.push_back(it);
	endtask

	// one seek: a start, then a measurement profile with a bump somewhere;
	// some runs are cut short and some stray transactions are mixed in
	task automatic queue_seek(input int max_freqs, input int f_lo, input int f_hi);
		int n_freq, peak_at, level, v, n_samp;
		push_item(fmspd_pkg::OP_START, int'($urandom_range(f_lo, f_hi)),
			1'($urandom_range(0, 1)), 0, 0);
		n_freq  = int'($urandom_range(1, max_freqs));
		peak_at = int'($urandom_range(0, n_freq));
		for (int k = 0; k < n_freq; k++) begin
			if (k == peak_at)
				level = int'($urandom_range(0, 120));
			else
				level = int'($urandom_range(0, 70)) - 60;
			if ($urandom_range(0, 7) == 0) level = int'($urandom_range(0, 255)) - 128;
			n_samp = ($urandom_range(0, 11) == 0) ? int'($urandom_range(0, SPF - 1)) : SPF;
			for (int s = 0; s < n_samp; s++) begin
				v = level + int'($urandom_range(0, 6)) - 3;
				if (v > 127) v = 127;
				if (v < -128) v = -128;
				push_item(fmspd_pkg::OP_SAMPLE, 0, 1'b0, v,
					($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 255)) - 128
					                             : int'($urandom_range(0, 40)));
			end
			// stray transaction with every field random
			if ($urandom_range(0, 9) == 0)
				push_item(1'($urandom_range(0, 1)), int'($urandom_range(0, 131071)),
					1'($urandom_range(0, 1)), int'($urandom_range(0, 255)) - 128,
					int'($urandom_range(0, 255)) - 128);
			if (n_samp != SPF) break;
		end
	endtask

	// keep the input queue topped up until enough transactions have been accepted,
	// then drop what is still pending
	task automatic run_seeks(input int target, input int max_freqs, input int f_lo,
			input int f_hi);
		int base;
		base = accepted_items;
		while (accepted_items - base < target) begin
			if (stim_q.size() < 16)
				queue_seek(max_freqs, f_lo, f_hi);
			else
				@(negedge clk);
		end
		stim_q.delete();
	endtask

	// all stimulus accepted and every expected result seen
	task automatic wait_drained();
		do @(posedge clk);
		while (stim_q.size() != 0 || s_tvalid || seek_results_due.size() != 0);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [16:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_addr  <= idx;
		cfg_data  <= val;
		do @(posedge clk);
		while (!cfg_ready);
		case (idx)
			fmspd_pkg::REG_BAND_LOW:   band_lo = val;
			fmspd_pkg::REG_BAND_HIGH:  band_hi = val;
			fmspd_pkg::REG_STEP_SIZE:  step_khz = val[11:0];
			fmspd_pkg::REG_PEAK_RISE:  rise_min = val[7:0];
			fmspd_pkg::REG_SNR_MIN:    snr_need = val[7:0];
			fmspd_pkg::REG_STEREO_OFS: stereo_ofs = val[7:0];
			fmspd_pkg::REG_CHAN_CUT:   chan_cut_rise = val[7:0];
			fmspd_pkg::REG_STEREO_CUT: lr_cut_rise = val[7:0];
			default: ;
		endcase
	endtask

	// new register set, only once the block has gone quiet
	task automatic set_config(input int lo, input int hi, input int stp, input int rise,
			input int snr, input int ofs, input int ccut, input int scut);
		wait_drained();
		repeat (LAT_PAD) @(posedge clk);
		write_reg(fmspd_pkg::REG_BAND_LOW, 17'(lo));
		write_reg(fmspd_pkg::REG_BAND_HIGH, 17'(hi));
		write_reg(fmspd_pkg::REG_STEP_SIZE, 17'(stp & 'hfff));
		write_reg(fmspd_pkg::REG_PEAK_RISE, 17'(rise & 'hff));
		write_reg(fmspd_pkg::REG_SNR_MIN, 17'(snr & 'hff));
		write_reg(fmspd_pkg::REG_STEREO_OFS, 17'(ofs & 'hff));
		write_reg(fmspd_pkg::REG_CHAN_CUT, 17'(ccut & 'hff));
		write_reg(fmspd_pkg::REG_STEREO_CUT, 17'(scut & 'hff));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int lo, hi, f_lo, f_hi;
		for (int i = 0; i < 4; i++) begin
			win_f[i] = 0;
			win_r[i] = 0;
			win_s[i] = 0;
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part under the reset register values
		push_item(fmspd_pkg::OP_SAMPLE, 0, 1'b0, 127, 127);  // sample while idle, dropped
		push_item(fmspd_pkg::OP_START, 0, 1'b1, 0, 0);       // below band both ways, ends at once
		push_item(fmspd_pkg::OP_START, 131071, 1'b0, 0, 0);  // above band both ways, ends at once
		push_item(fmspd_pkg::OP_START, 95800, 1'b0, 0, 0);   // walks over the forbidden frequency
		for (int s = 0; s < SPF; s++) push_item(fmspd_pkg::OP_SAMPLE, 0, 1'b0, -128, -128);
		for (int s = 0; s < SPF; s++) push_item(fmspd_pkg::OP_SAMPLE, 0, 1'b0, 127, 127);
		for (int s = 0; s < SPF; s++) push_item(fmspd_pkg::OP_SAMPLE, 0, 1'b0, -128, 0);
		for (int s = 0; s < SPF; s++) push_item(fmspd_pkg::OP_SAMPLE, 0, 1'b0, -128, -128);
		wait_drained();
		// random seeks, default band, start while seeking comes with each new seek
		run_seeks(200, 10, 86000, 110000);

		// narrow band so seeks come back round to their start point
		set_config(90000, 90500, 100, 8, 4, 22, 15, 12);
		run_seeks(250, 12, 89800, 90700);

		// extremes: full band, largest step, every compare as loose or tight as it gets
		set_config(0, 131071, 4095, -128, -128, 127, 127, -128);
		hold_req = 1;
		run_seeks(250, 10, 0, 131071);

		// the other extremes, a tiny band around the forbidden frequency, no idling
		no_idle = 1;
		set_config(95990, 96010, 1, 127, 127, -128, -128, 127);
		run_seeks(200, 30, 95980, 96020);
		no_idle = 0;

		// zero step: every seek ends at once
		set_config(87400, 108000, 0, 8, 4, 22, 15, 12);
		run_seeks(40, 4, 86000, 110000);

		// inverted band
		set_config(100000, 90000, 300, 5, 0, -30, 20, 10);
		run_seeks(150, 8, 85000, 105000);

		// random register sets
		for (int p = 0; p < 3; p++) begin
			no_idle = (p == 1);
			lo = int'($urandom_range(0, 125000));
			hi = lo + int'($urandom_range(200, 6000));
			if (hi > 131071) hi = 131071;
			set_config(lo, hi, int'($urandom_range(1, 700)),
				int'($urandom_range(0, 30)) - 6, int'($urandom_range(0, 30)) - 10,
				int'($urandom_range(0, 255)) - 128, int'($urandom_range(0, 255)) - 128,
				int'($urandom_range(0, 255)) - 128);
			f_lo = (lo > 500) ? lo - 500 : 0;
			f_hi = (hi < 130571) ? hi + 500 : 131071;
			run_seeks(200, 12, f_lo, f_hi);
		end
		no_idle = 0;

		// let the pipeline empty, then report
		wait_drained();
		repeat (LAT_PAD) @(posedge clk);
		if (mismatch_count == 0 && seek_results_due.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: fm_seek_peak_detector_unit.f
sv/fmspd_pkg.sv
sv/fm_seek_peak_detector_unit.sv
tb/tb_top.sv
